/* hw/rtl/mlfd_pkg.sv */
// ============================================================================
// mlfd_pkg
// Shared types and constants for the magic/length frame deframer.
// ============================================================================
package mlfd_pkg;

    // Header is type byte plus 24-bit big-endian length
    localparam int unsigned HDR_BYTES   = 4;
    localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);
    localparam int unsigned LEN_W       = 24;
    localparam int unsigned BYTE_W      = 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = LEN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 2'd0,
        REG_MAX_LEN = 2'd1
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] MAGIC_RESET   = 8'd165;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 24'd16384;

    // Received word
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              restart;
    } rx_word_t;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0] msg_type;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  msg_len;
        logic              last_flag;
        logic              empty_msg;
    } msg_word_t;

    // Input stage contents handed to the parser
    typedef struct packed {
        logic     valid;
        rx_word_t word;
    } in_stage_t;

    // Parser result handed to the output register
    typedef struct packed {
        logic      valid;
        msg_word_t word;
    } result_t;

endpackage

/* hw/rtl/mlfd_if.sv */
// ============================================================================
// mlfd_if
// Valid/ready channel interfaces for received bytes and message words.
// ============================================================================
interface mlfd_rx_if;
    import mlfd_pkg::*;

    logic     valid;
    logic     ready;
    rx_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mlfd_msg_if;
    import mlfd_pkg::*;

    logic      valid;
    logic      ready;
    msg_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/mlfd_in_reg.sv */
// ============================================================================
// mlfd_in_reg
// Input register: captures one received word per cycle from the channel, unless a held
// word still waits for the parser.
module mlfd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    mlfd_rx_if.sink             in_ch,
    input  logic                take,
    output mlfd_pkg::in_stage_t stage
);
    import mlfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_word_t word_reg;
    logic     load;

    // Free when empty or when the held word moves on this cycle
    assign in_ch.ready = !valid_reg || take;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= in_ch.data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

/* hw/rtl/mlfd_parser.sv */
// ============================================================================
// mlfd_parser
// Frame parser: magic hunt, header gather, payload streaming, config regs.
// ============================================================================
module mlfd_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  mlfd_pkg::in_stage_t                 stage,
    input  logic                                out_free,
    output logic                                take,
    output mlfd_pkg::result_t                   result
);
    import mlfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [BYTE_W-1:0]     type_reg,    type_next;
    logic [LEN_W-1:0]      len_reg,     len_next;
    logic [LEN_W-1:0]      count_reg,   count_next;
    logic [BYTE_W-1:0]     magic_reg;
    logic [LEN_W-1:0]      max_len_reg;

    logic [BYTE_W-1:0]     b;
    logic [LEN_W-1:0]      len_full;
    logic [LEN_W-1:0]      count_inc;
    logic                  pay_last;
    logic                  emit;
    msg_word_t             res_word;

    assign b         = stage.word.rx_byte;
    assign len_full  = {len_reg[LEN_W-BYTE_W-1:0], b};
    assign count_inc = count_reg + 1'b1;
    assign pay_last  = (count_inc == len_reg);

    // Next state and result for the word in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        res_word     = '{msg_type: type_reg, payload_byte: b, msg_len: len_reg,
                         last_flag: 1'b0, empty_msg: 1'b0};

        if (stage.word.restart)
        begin
            phase_next   = PH_HUNT;
            hdr_idx_next = '0;
            type_next    = '0;
            len_next     = '0;
            count_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == '0)
                    begin
                        type_next = b;
                        len_next  = '0;
                    end
                    else
                    begin
                        len_next = len_full;
                    end
                    // Fourth header byte: decide the frame's fate
                    if (hdr_idx_reg == HDR_IDX_W'(HDR_BYTES - 1))
                    begin
                        count_next = '0;
                        if (len_full == '0)
                        begin
                            emit                  = 1'b1;
                            res_word.payload_byte = '0;
                            res_word.msg_len      = '0;
                            res_word.last_flag    = 1'b1;
                            res_word.empty_msg    = 1'b1;
                            phase_next            = PH_HUNT;
                            type_next             = '0;
                            len_next              = '0;
                        end
                        else if (len_full > max_len_reg)
                        begin
                            // oversize: drop and resync
                            phase_next = PH_HUNT;
                            type_next  = '0;
                            len_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit               = 1'b1;
                    res_word.last_flag = pay_last;
                    if (pay_last)
                    begin
                        phase_next   = PH_HUNT;
                        hdr_idx_next = '0;
                        type_next    = '0;
                        len_next     = '0;
                        count_next   = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    hdr_idx_next = '0;
                    if (b == magic_reg)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Word moves on unless its result would find the output register full
    assign take         = stage.valid && (out_free || !emit);
    assign result.valid = take && emit;
    assign result.word  = res_word;

    // Parser state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            hdr_idx_reg <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            magic_reg   <= MAGIC_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                type_reg    <= type_next;
                len_reg     <= len_next;
                count_reg   <= count_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAGIC:   magic_reg   <= cfg_wdata[BYTE_W-1:0];
                    REG_MAX_LEN: max_len_reg <= cfg_wdata[LEN_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/mlfd_out_reg.sv */
// ============================================================================
// mlfd_out_reg
// Result register: holds one message word until the sink takes it.
// ============================================================================
module mlfd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  mlfd_pkg::result_t result,
    output logic              out_free,
    mlfd_msg_if.source        out_ch
);
    import mlfd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    msg_word_t word_reg;

    // Can load when empty or when the held word leaves this cycle
    assign out_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            word_reg <= result.word;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.data  = word_reg;

endmodule

/* hw/rtl/magic_length_frame_deframer_top.sv */
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle; the parser handles one byte from its input register
// each cycle, stalling only while a result waits in a full output register.
// Reset: rst_n clears both stages and returns the parser to magic hunting; magic
// value resets to 165 and the maximum payload length to 16384.
// ============================================================================
// magic_length_frame_deframer_top
// Deframes magic-byte, length-prefixed frames into a stream of payload words.
// ============================================================================
module magic_length_frame_deframer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    mlfd_rx_if.sink                         in_ch,
    mlfd_msg_if.source                      out_ch
);
    import mlfd_pkg::*;

    in_stage_t stage;
    result_t   result;
    logic      take;
    logic      out_free;

    mlfd_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (take),
        .stage (stage)
    );

    mlfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .out_free  (out_free),
        .take      (take),
        .result    (result)
    );

    mlfd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .out_free (out_free),
        .out_ch   (out_ch)
    );

endmodule
